>>> hdl/bfci_pkg.sv
// Shared constants for the canonical-insert bloom filter.
`timescale 1ns / 1ps
`default_nettype none
package bfci_pkg;

    localparam int unsigned FILTER_BITS_DEF = 1048576;
    localparam int unsigned MAX_HASHES_DEF  = 5;
    localparam int unsigned HASH_WIDTH_DEF  = 64;
    localparam int unsigned NUM_KINDS       = 5;
    localparam int unsigned CHAR_W          = 7;
    localparam int unsigned HCNT_W          = 3;
    localparam int unsigned BCNT_W          = 21;
    localparam int unsigned CFG_ADDR_W      = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_HASH_COUNT = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BIT_COUNT  = 1'd1;

endpackage : bfci_pkg
`default_nettype wire

>>> hdl/bfci_hash.sv
// Running string hashes for one key, advanced one character per word.
`timescale 1ns / 1ps
`default_nettype none
module bfci_hash
    import bfci_pkg::*;
#(
    parameter int unsigned HASH_WIDTH = HASH_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire logic                  clear,
    input  wire logic [CHAR_W-1:0]     chr,
    input  wire logic [2:0]            sel,
    output logic      [HASH_WIDTH-1:0] hash
);

    logic [HASH_WIDTH-1:0] h_reg  [NUM_KINDS];
    logic [HASH_WIDTH-1:0] h_next [NUM_KINDS];
    logic [HASH_WIDTH-1:0] c;

    assign c = HASH_WIDTH'(chr);

    always_comb
    begin
        h_next[0] = h_reg[0] ^ ((h_reg[0] << 5) + (h_reg[0] >> 2) + c);
        h_next[1] = c + (h_reg[1] << 6) + (h_reg[1] << 16) - h_reg[1];
        h_next[2] = h_reg[2] + c;
        h_next[3] = h_reg[3] ^ c;
        h_next[4] = (h_reg[4] << 5) + h_reg[4] + c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_KINDS; i++) h_reg[i] <= '0;
        end
        else if (clear)
        begin
            for (int i = 0; i < NUM_KINDS; i++) h_reg[i] <= '0;
        end
        else if (step)
        begin
            for (int i = 0; i < NUM_KINDS; i++) h_reg[i] <= h_next[i];
        end
    end

    always_comb
    begin
        case (sel)
            3'd0:    hash = h_reg[0];
            3'd1:    hash = h_reg[1];
            3'd2:    hash = h_reg[2];
            3'd3:    hash = h_reg[3];
            default: hash = h_reg[4];
        endcase
    end

endmodule : bfci_hash
`default_nettype wire

>>> hdl/bfci_mod.sv
// Restoring remainder unit: one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module bfci_mod
    import bfci_pkg::*;
#(
    parameter int unsigned HASH_WIDTH = HASH_WIDTH_DEF,
    parameter int unsigned MW         = BCNT_W
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [HASH_WIDTH-1:0] dividend,
    input  wire logic [MW-1:0]         modulus,
    output logic                       done,
    output logic      [MW-1:0]         rem
);

    localparam int unsigned CW = $clog2(HASH_WIDTH + 1);

    logic [HASH_WIDTH-1:0] q_reg;
    logic [MW:0]           r_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  busy_reg;
    logic [MW+1:0]         shifted;
    logic [MW+1:0]         diff;

    assign shifted = {r_reg, q_reg[HASH_WIDTH-1]};
    assign diff    = shifted - (MW+2)'(modulus);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= !start && busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(HASH_WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg <= q_reg << 1;
            if (!diff[MW+1]) r_reg <= diff[MW:0];
            else             r_reg <= shifted[MW:0];
        end
    end

    assign rem = r_reg[MW-1:0];

endmodule : bfci_mod
`default_nettype wire

>>> hdl/bloom_filter_canonical_insert.sv
// Top level: hash front end, remainder unit and bit store sequencer.
// Usage:
//   in channel (in_valid/in_ready) carries fwd_char, rev_char, last; one
//   word per key character. Non-last words are absorbed straight into the hashes.
//   On a last word the block reduces up to 2*hash_count hashes modulo
//   bit_count, each in the bit-serial remainder unit followed by a store
//   read and a compare, then, if the key was not seen, writes back
//   hash_count bits, each with a read and a write of its store word.
//   out channel (out_valid/out_ready) gives key_seen once per key; a held
//   result does not block the next key's characters, only its end.
//   cfg channel writes hash_count (index 0) or bit_count (index 1).
//   After reset a clearing pass walks the store one word per cycle,
//   with in_ready low.
`timescale 1ns / 1ps
`default_nettype none
module bloom_filter_canonical_insert
    import bfci_pkg::*;
#(
    parameter int unsigned FILTER_BITS = FILTER_BITS_DEF,
    parameter int unsigned MAX_HASHES  = MAX_HASHES_DEF,
    parameter int unsigned HASH_WIDTH  = HASH_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [CHAR_W-1:0]     fwd_char,
    input  wire logic [CHAR_W-1:0]     rev_char,
    input  wire logic                  last,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       key_seen,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0] cfg_index,
    input  wire logic [BCNT_W-1:0]     cfg_data
);

    localparam int unsigned BW    = (FILTER_BITS < 64) ? 8 : 64;
    localparam int unsigned LBW   = $clog2(BW);
    localparam int unsigned WORDS = (FILTER_BITS + BW - 1) / BW;
    localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int unsigned NB    = $clog2(FILTER_BITS + 1);
    localparam int unsigned MW    = (NB > BCNT_W) ? NB : BCNT_W;
    localparam int unsigned NKEEP = (MAX_HASHES < NUM_KINDS) ? MAX_HASHES : NUM_KINDS;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_RUN   = 7'b0000010,
        S_MOD   = 7'b0000100,
        S_READ  = 7'b0001000,
        S_EVAL  = 7'b0010000,
        S_WRITE = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg;

    logic [HCNT_W-1:0] hcnt_reg;
    logic [BCNT_W-1:0] bcnt_reg;

    // store
    logic [BW-1:0] mem [WORDS];
    logic [BW-1:0] rd_data_reg;
    logic [AW-1:0] clr_reg;

    logic [2:0]    idx_reg;
    logic          rev_reg;
    logic          fwd_all_reg;
    logic [MW-1:0] pos_reg [NUM_KINDS];
    logic [2:0]    n_eff;
    logic [MW-1:0] m_eff;

    logic                  hstep;
    logic [HASH_WIDTH-1:0] fhash, rhash;
    logic                  mstart, mdone;
    logic [MW-1:0]         mrem;
    logic [MW-1:0]         cur_pos;
    logic [AW-1:0]         cur_addr;
    logic                  bit_hit;
    logic                  res_reg;
    logic                  last_idx;
    logic                  enter_mod;

    always_comb
    begin
        if (hcnt_reg == '0)                      n_eff = 3'd1;
        else if (32'(hcnt_reg) > NKEEP)          n_eff = 3'(NKEEP);
        else                                     n_eff = hcnt_reg;
        if (bcnt_reg == '0)                      m_eff = MW'(1);
        else if (32'(bcnt_reg) > FILTER_BITS)    m_eff = MW'(FILTER_BITS);
        else                                     m_eff = MW'(bcnt_reg);
    end

    assign in_ready  = (state_reg == S_RUN) && !(last && out_valid);
    assign cfg_ready = 1'b1;
    assign hstep     = in_valid && in_ready;
    assign last_idx  = (idx_reg == n_eff - 3'd1);

    // a remainder run starts at a key end and after every probe that goes on
    assign enter_mod = (state_reg == S_RUN && hstep && last)
                       || (state_reg == S_EVAL && !rev_reg
                           && !(last_idx && fwd_all_reg && bit_hit))
                       || (state_reg == S_EVAL && rev_reg && bit_hit && !last_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hcnt_reg <= HCNT_W'(MAX_HASHES_DEF);
            bcnt_reg <= BCNT_W'(FILTER_BITS_DEF);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_HASH_COUNT: hcnt_reg <= cfg_data[HCNT_W-1:0];
                REG_BIT_COUNT:  bcnt_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic clr_hashes;
    assign clr_hashes = (state_reg == S_OUT);

    bfci_hash #(.HASH_WIDTH(HASH_WIDTH)) u_fwd (
        .clk(clk), .rst_n(rst_n), .step(hstep), .clear(clr_hashes),
        .chr(fwd_char), .sel(idx_reg), .hash(fhash)
    );

    bfci_hash #(.HASH_WIDTH(HASH_WIDTH)) u_rev (
        .clk(clk), .rst_n(rst_n), .step(hstep), .clear(clr_hashes),
        .chr(rev_char), .sel(idx_reg), .hash(rhash)
    );

    bfci_mod #(.HASH_WIDTH(HASH_WIDTH), .MW(MW)) u_mod (
        .clk(clk), .rst_n(rst_n), .start(mstart),
        .dividend(rev_reg ? rhash : fhash), .modulus(m_eff),
        .done(mdone), .rem(mrem)
    );

    logic [MW-1:0] rem_reg;
    assign cur_pos  = (state_reg == S_WRITE) ? pos_reg[idx_reg] : rem_reg;
    assign cur_addr = AW'(cur_pos >> LBW);
    assign bit_hit  = rd_data_reg[cur_pos[LBW-1:0]];

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
            mem[clr_reg] <= '0;
        else if (state_reg == S_WRITE && rev_reg)
            mem[cur_addr] <= rd_data_reg | (BW'(1) << cur_pos[LBW-1:0]);
        rd_data_reg <= mem[cur_addr];
        if (mdone) rem_reg <= mrem;
        if (state_reg == S_EVAL && !rev_reg) pos_reg[idx_reg] <= rem_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mstart <= 1'b0;
        else
            mstart <= enter_mod;
    end

    // S_WRITE: rev_reg doubles as read(0)/write(1) phase flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            idx_reg     <= '0;
            rev_reg     <= 1'b0;
            fwd_all_reg <= 1'b1;
            out_valid   <= 1'b0;
            res_reg     <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready) out_valid <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (32'(clr_reg) == WORDS - 1) state_reg <= S_RUN;
                end
                S_RUN:
                begin
                    if (hstep && last)
                    begin
                        idx_reg     <= '0;
                        rev_reg     <= 1'b0;
                        fwd_all_reg <= 1'b1;
                        state_reg   <= S_MOD;
                    end
                end
                S_MOD:
                    if (mdone) state_reg <= S_READ;
                S_READ:
                    state_reg <= S_EVAL;
                S_EVAL:
                begin
                    if (!rev_reg)
                    begin
                        if (!bit_hit) fwd_all_reg <= 1'b0;
                        if (last_idx)
                        begin
                            if (fwd_all_reg && bit_hit)
                            begin
                                res_reg   <= 1'b1;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                idx_reg   <= '0;
                                rev_reg   <= 1'b1;
                                state_reg <= S_MOD;
                            end
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_MOD;
                        end
                    end
                    else if (!bit_hit)
                    begin
                        idx_reg   <= '0;
                        rev_reg   <= 1'b0;
                        state_reg <= S_WRITE;
                    end
                    else if (last_idx)
                    begin
                        res_reg   <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_MOD;
                    end
                end
                S_WRITE:
                begin
                    // read word, then write it back with the bit set
                    rev_reg <= !rev_reg;
                    if (rev_reg)
                    begin
                        if (last_idx)
                        begin
                            res_reg   <= 1'b0;
                            state_reg <= S_OUT;
                        end
                        else
                            idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_OUT:
                begin
                    out_valid <= 1'b1;
                    state_reg <= S_RUN;
                end
                default: state_reg <= S_CLEAR;
            endcase
        end
    end

    assign key_seen = res_reg;

endmodule : bloom_filter_canonical_insert
`default_nettype wire

>>> hdl/bfci_checker.sv
// Port-level checker for the bloom filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bfci_checker
    import bfci_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              last,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic              key_seen
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(key_seen))
        else $error("result dropped while stalled");

    a_no_out_without_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while taking characters");

    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last |=> !in_ready)
        else $error("key end did not start a lookup");

endmodule : bfci_checker

bind bloom_filter_canonical_insert bfci_checker u_bfci_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .last(last), .out_valid(out_valid), .out_ready(out_ready),
    .key_seen(key_seen)
);
`default_nettype wire

>>> tb/tb_bloom_filter_canonical_insert.sv
// Self-checking testbench for the canonical-insert bloom filter.
`timescale 1ns / 1ps
module tb_bloom_filter_canonical_insert;
    import bfci_pkg::*;

    localparam int MAX_KEY     = 16;
    localparam int DRAIN_WAIT  = 1200;
    localparam int STALL_LIMIT = 200000;

    typedef struct packed {
        logic [CHAR_W-1:0] fwd;
        logic [CHAR_W-1:0] rev;
        logic              fin;
    } word_t;

    typedef bit [63:0] hset_t [NUM_KINDS];
    typedef bit [MAX_KEY*CHAR_W-1:0] keybuf_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [CHAR_W-1:0]     fwd_char = '0;
    logic [CHAR_W-1:0]     rev_char = '0;
    logic                  last = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  key_seen;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_index = '0;
    logic [BCNT_W-1:0]     cfg_data = '0;

    word_t   word_queue[$];
    bit      seen_queue[$];
    keybuf_t key_bank[$];
    int      key_len_bank[$];

    // filter mirror and running hashes
    bit      filter_bits [FILTER_BITS_DEF];
    hset_t   fwd_h;
    hset_t   rev_h;
    bit [HCNT_W-1:0] hash_count_m;
    bit [BCNT_W-1:0] bit_count_m;

    int  errors = 0;
    int  idle_cycles = 0;
    bit  quiet = 1'b0;
    int  phase_words;

    bloom_filter_canonical_insert dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .fwd_char  (fwd_char),
        .rev_char  (rev_char),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .key_seen  (key_seen),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic hset_t mix_char(hset_t h, bit [63:0] c);
        hset_t r;
        r[0] = h[0] ^ ((h[0] << 5) + (h[0] >> 2) + c);
        r[1] = c + (h[1] << 6) + (h[1] << 16) - h[1];
        r[2] = h[2] + c;
        r[3] = h[3] ^ c;
        r[4] = h[4] * 64'd33 + c;
        return r;
    endfunction

    function automatic void absorb_word(bit [CHAR_W-1:0] f, bit [CHAR_W-1:0] r, bit fin);
        int        n;
        bit [63:0] m;
        bit [63:0] slot [NUM_KINDS];
        bit        fwd_all;
        bit        rev_all;
        fwd_h = mix_char(fwd_h, 64'(f));
        rev_h = mix_char(rev_h, 64'(r));
        if (!fin)
            return;
        n = hash_count_m;
        if (n < 1) n = 1;
        if (n > MAX_HASHES_DEF) n = MAX_HASHES_DEF;
        m = bit_count_m;
        if (m < 1) m = 1;
        if (m > FILTER_BITS_DEF) m = FILTER_BITS_DEF;
        fwd_all = 1'b1;
        rev_all = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            slot[i] = fwd_h[i] % m;
            if (!filter_bits[slot[i]])
                fwd_all = 1'b0;
        end
        for (int i = 0; i < n; i++)
            if (!filter_bits[rev_h[i] % m])
                rev_all = 1'b0;
        if (fwd_all || rev_all)
            seen_queue.push_back(1'b1);
        else
        begin
            for (int i = 0; i < n; i++)
                filter_bits[slot[i]] = 1'b1;
            seen_queue.push_back(1'b0);
        end
        for (int i = 0; i < NUM_KINDS; i++)
        begin
            fwd_h[i] = '0;
            rev_h[i] = '0;
        end
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                absorb_word(fwd_char, rev_char, last);
            if (!in_valid || in_ready)
            begin
                if (word_queue.size() > 0 && (quiet || $urandom_range(99) >= 38))
                begin
                    in_valid <= 1'b1;
                    fwd_char <= word_queue[0].fwd;
                    rev_char <= word_queue[0].rev;
                    last     <= word_queue[0].fin;
                    void'(word_queue.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            out_ready <= quiet || $urandom_range(99) >= 38;
            if (out_valid && out_ready)
            begin
                if (seen_queue.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none actual key_seen=%0d",
                             $time, key_seen);
                    errors++;
                end
                else if (seen_queue[0] !== key_seen)
                begin
                    $display("%0t: key_seen mismatch, expected %0d actual %0d",
                             $time, seen_queue[0], key_seen);
                    errors++;
                    void'(seen_queue.pop_front());
                end
                else
                    void'(seen_queue.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [BCNT_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_HASH_COUNT)
            hash_count_m = value[HCNT_W-1:0];
        else
            bit_count_m = value;
    endtask

    // queue a key; well-formed keys carry their exact reverse alongside
    task automatic push_key(keybuf_t k, int len, bit broken);
        word_t w;
        for (int i = 0; i < len; i++)
        begin
            w.fwd = k[i*CHAR_W +: CHAR_W];
            w.rev = broken ? CHAR_W'($urandom_range(127)) : k[(len-1-i)*CHAR_W +: CHAR_W];
            w.fin = (i == len - 1);
            word_queue.push_back(w);
        end
        key_bank.push_back(k);
        key_len_bank.push_back(len);
        phase_words += len;
    endtask

    function automatic keybuf_t flip_key(keybuf_t k, int len);
        keybuf_t r;
        r = '0;
        for (int i = 0; i < len; i++)
            r[i*CHAR_W +: CHAR_W] = k[(len-1-i)*CHAR_W +: CHAR_W];
        return r;
    endfunction

    task automatic random_keys(int words);
        keybuf_t k;
        int      len;
        int      pick;
        int      sel;
        phase_words = 0;
        while (phase_words < words)
        begin
            pick = $urandom_range(99);
            if (pick < 45 || key_bank.size() == 0)
            begin
                len = ($urandom_range(19) == 0) ? MAX_KEY : $urandom_range(1, 8);
                for (int i = 0; i < MAX_KEY; i++)
                    k[i*CHAR_W +: CHAR_W] = CHAR_W'((i < len) ? $urandom_range(127) : 0);
                push_key(k, len, $urandom_range(9) == 0);
            end
            else
            begin
                sel = $urandom_range(key_bank.size() - 1);
                len = key_len_bank[sel];
                k = key_bank[sel];
                if (pick < 75)
                    push_key(k, len, 1'b0);
                else
                    push_key(flip_key(k, len), len, pick >= 95);
            end
        end
    endtask

    task automatic drain();
        while (word_queue.size() > 0 || in_valid || seen_queue.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    initial
    begin
        keybuf_t k;
        hash_count_m = 3'd5;
        bit_count_m  = BCNT_W'(FILTER_BITS_DEF);
        for (int i = 0; i < NUM_KINDS; i++)
        begin
            fwd_h[i] = '0;
            rev_h[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, extremes of characters and lengths
        phase_words = 0;
        k = '1;
        push_key(k, MAX_KEY, 1'b0);           // all 127, longest
        k = '0;
        push_key(k, 1, 1'b0);                 // zero character, length one
        push_key(k, 1, 1'b0);                 // same again: seen
        k = {16{7'h55}} ^ 112'h1;
        push_key(k, 3, 1'b0);
        push_key(flip_key(k, 3), 3, 1'b0);    // reverse form: seen via reverse
        k = 112'h2A_1540_aa;
        push_key(k, 4, 1'b1);                 // reverse does not match
        drain();

        write_reg(REG_HASH_COUNT, BCNT_W'(1));
        write_reg(REG_BIT_COUNT, BCNT_W'(1));
        random_keys(100);
        drain();

        quiet = 1'b1;
        write_reg(REG_HASH_COUNT, BCNT_W'(0));
        write_reg(REG_BIT_COUNT, BCNT_W'(0));
        random_keys(100);
        drain();
        quiet = 1'b0;

        write_reg(REG_HASH_COUNT, BCNT_W'(7));
        write_reg(REG_BIT_COUNT, 21'h1FFFFF);
        random_keys(100);
        drain();

        write_reg(REG_HASH_COUNT, BCNT_W'(3));
        write_reg(REG_BIT_COUNT, BCNT_W'(1000));
        random_keys(100);
        drain();

        write_reg(REG_HASH_COUNT, BCNT_W'(2));
        write_reg(REG_BIT_COUNT, BCNT_W'(64));
        random_keys(100);
        drain();

        write_reg(REG_HASH_COUNT, BCNT_W'(5));
        write_reg(REG_BIT_COUNT, BCNT_W'(FILTER_BITS_DEF));
        random_keys(100);
        drain();

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
